FILE: rtl/dre_pkg.sv
// Package for the DNS response IPv4 extractor.
// Holds the parse phase type, DNS constants and the default message limit.
// No dependencies; the core, the checker and the testbench use it by scoped names.
package dre_pkg;

  // Default number of message bytes that are parsed; later bytes are ignored.
  localparam int unsigned MAX_MSG_BYTES_DEF = 512;

  // A label length byte with both top bits set starts a compression pointer.
  localparam logic [7:0]  PTR_MASK    = 8'hc0;
  localparam logic [15:0] TYPE_A_CODE = 16'h0001;
  localparam logic [15:0] A_RDLENGTH  = 16'h0004;

  // Byte positions inside the fixed header.
  localparam int unsigned HDR_FLAGS_LO = 3;
  localparam int unsigned HDR_QD_HI    = 4;
  localparam int unsigned HDR_QD_LO    = 5;
  localparam int unsigned HDR_AN_HI    = 6;
  localparam int unsigned HDR_AN_LO    = 7;
  localparam int unsigned HDR_LAST     = 11;

  // Byte positions inside the fixed part of a question and of an answer.
  localparam logic [3:0] Q_FIXED_LEN  = 4'd4;
  localparam logic [3:0] A_TYPE_HI    = 4'd0;
  localparam logic [3:0] A_TYPE_LO    = 4'd1;
  localparam logic [3:0] A_RDLEN_HI   = 4'd8;
  localparam logic [3:0] A_RDLEN_LO   = 4'd9;
  localparam logic [3:0] A_FIXED_LEN  = 4'd10;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_Q_NAME  = 4'd1,
    PH_Q_PTR   = 4'd2,
    PH_Q_FIXED = 4'd3,
    PH_A_NAME  = 4'd4,
    PH_A_PTR   = 4'd5,
    PH_A_FIXED = 4'd6,
    PH_RDATA   = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

endpackage

FILE: rtl/dre_if.sv
// Channel interfaces of the DNS response IPv4 extractor.
// dre_in_if carries message bytes, dre_out_if carries results.
// No dependencies.
interface dre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, output msg_byte, output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface

interface dre_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ip_addr;
  logic        ip_found;
  logic [3:0]  rcode;
  logic        fail;
  logic        truncated;

  modport source (output valid, output ip_addr, output ip_found, output rcode,
                  output fail, output truncated, input ready);
  modport sink   (input valid, input ip_addr, input ip_found, input rcode,
                  input fail, input truncated, output ready);
endinterface

FILE: rtl/dns_response_ipv4_extractor_core.sv
// Top level of the DNS response IPv4 extractor.
// Depends on dre_pkg (phase type, constants) and dre_if.sv (channel interfaces).
//
// Usage
//   A DNS response enters on the msg channel one byte per transaction, with
//   last_byte high on the final byte. The parser walks the header, the
//   questions and the answer records and keeps the address of the last A
//   record whose rdlength is four. Bytes beyond MAX_MSG_BYTES are counted
//   no further and are not parsed.
//   The transaction carrying the last byte produces exactly one result on the
//   res channel: ip_addr, ip_found, rcode, fail and truncated. All other
//   bytes produce nothing. The parse state then returns to its reset value, so
//   the next byte starts a new message.
//   Throughput: one byte per cycle while msg.ready is high, as the parse state
//   registers update on every accepted byte. Result: the result is valid the
//   cycle after the last byte is accepted, from the result register.
//   Stalling: while a result waits in the result register and the receiver
//   holds ready low, msg.ready is low; otherwise a byte is taken each cycle,
//   including the cycle in which a waiting result is taken.
//   Reset (rst, synchronous, active high) clears the parse state and empties
//   the result register.
module dns_response_ipv4_extractor_core #(
  parameter int unsigned MAX_MSG_BYTES = dre_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dre_in_if.sink            msg,
  dre_out_if.source         res
);

  localparam int unsigned CountW = $clog2(MAX_MSG_BYTES + 1);

  // Parse state.
  dre_pkg::phase_t phase, phase_next;
  logic [3:0]        field_pos, field_pos_next;
  logic [15:0]       questions_left, questions_left_next;
  logic [15:0]       answers_left, answers_left_next;
  logic [7:0]        label_left, label_left_next;
  logic [15:0]       record_type, record_type_next;
  logic [15:0]       rdata_left, rdata_left_next;
  logic [31:0]       ip_shift, ip_shift_next;
  logic              found_flag, found_flag_next;
  logic [3:0]        response_code, response_code_next;
  logic [CountW-1:0] byte_count, byte_count_next;

  logic       accept;
  logic       section_end;
  logic [7:0] b;
  logic [3:0] field_inc;

  // Result register.
  logic        res_valid;
  logic [31:0] res_ip;
  logic        res_found;
  logic [3:0]  res_rcode;
  logic        res_trunc;

  // A new byte is taken unless a result is stuck in the result register.
  assign msg.ready = !res_valid || res.ready;
  assign accept    = msg.valid && msg.ready;
  assign b         = msg.msg_byte;
  assign field_inc = field_pos + 4'd1;

  // Next parse state for the byte at the input. Assignments follow each other
  // in the order of the protocol, so a later step sees an earlier update.
  always_comb begin
    phase_next          = phase;
    field_pos_next      = field_pos;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    label_left_next     = label_left;
    record_type_next    = record_type;
    rdata_left_next     = rdata_left;
    ip_shift_next       = ip_shift;
    found_flag_next     = found_flag;
    response_code_next  = response_code;
    byte_count_next     = byte_count;
    section_end         = 1'b0;

    if (byte_count < CountW'(MAX_MSG_BYTES)) begin
      unique case (phase)
        dre_pkg::PH_HDR: begin
          priority if (byte_count == CountW'(dre_pkg::HDR_FLAGS_LO)) begin
            response_code_next = b[3:0];
          end else if (byte_count == CountW'(dre_pkg::HDR_QD_HI)) begin
            questions_left_next = {b, 8'h00};
          end else if (byte_count == CountW'(dre_pkg::HDR_QD_LO)) begin
            questions_left_next = questions_left | {8'h00, b};
          end else if (byte_count == CountW'(dre_pkg::HDR_AN_HI)) begin
            answers_left_next = {b, 8'h00};
          end else if (byte_count == CountW'(dre_pkg::HDR_AN_LO)) begin
            answers_left_next = answers_left | {8'h00, b};
          end else begin
          end
          if (byte_count >= CountW'(dre_pkg::HDR_LAST)) begin
            section_end = 1'b1;
          end
        end
        dre_pkg::PH_Q_NAME, dre_pkg::PH_A_NAME: begin
          priority if (label_left != 8'd0) begin
            label_left_next = label_left - 8'd1;
          end else if ((b & dre_pkg::PTR_MASK) == dre_pkg::PTR_MASK) begin
            phase_next = (phase == dre_pkg::PH_Q_NAME) ? dre_pkg::PH_Q_PTR
                                                       : dre_pkg::PH_A_PTR;
          end else if (b == 8'd0) begin
            phase_next     = (phase == dre_pkg::PH_Q_NAME) ? dre_pkg::PH_Q_FIXED
                                                           : dre_pkg::PH_A_FIXED;
            field_pos_next = 4'd0;
          end else begin
            label_left_next = b;
          end
        end
        dre_pkg::PH_Q_PTR: begin
          // Second pointer byte: the offset is not followed.
          phase_next     = dre_pkg::PH_Q_FIXED;
          field_pos_next = 4'd0;
        end
        dre_pkg::PH_A_PTR: begin
          phase_next     = dre_pkg::PH_A_FIXED;
          field_pos_next = 4'd0;
        end
        dre_pkg::PH_Q_FIXED: begin
          field_pos_next = field_inc;
          if (field_inc >= dre_pkg::Q_FIXED_LEN) begin
            questions_left_next = questions_left - 16'd1;
            section_end         = 1'b1;
          end
        end
        dre_pkg::PH_A_FIXED: begin
          priority if (field_pos == dre_pkg::A_TYPE_HI) begin
            record_type_next = {b, 8'h00};
          end else if (field_pos == dre_pkg::A_TYPE_LO) begin
            record_type_next = record_type | {8'h00, b};
          end else if (field_pos == dre_pkg::A_RDLEN_HI) begin
            rdata_left_next = {b, 8'h00};
          end else if (field_pos == dre_pkg::A_RDLEN_LO) begin
            rdata_left_next = rdata_left | {8'h00, b};
          end else begin
          end
          field_pos_next = field_inc;
          if (field_inc >= dre_pkg::A_FIXED_LEN) begin
            if (rdata_left_next == 16'd0) begin
              answers_left_next = answers_left - 16'd1;
              section_end       = 1'b1;
            end else begin
              // From here field_pos marks whether the rdata is an address.
              field_pos_next = {3'd0, (record_type_next == dre_pkg::TYPE_A_CODE)
                                      && (rdata_left_next == dre_pkg::A_RDLENGTH)};
              phase_next     = dre_pkg::PH_RDATA;
            end
          end
        end
        dre_pkg::PH_RDATA: begin
          if (field_pos != 4'd0) begin
            ip_shift_next = {ip_shift[23:0], b};
          end
          rdata_left_next = rdata_left - 16'd1;
          if (rdata_left_next == 16'd0) begin
            if (field_pos != 4'd0) begin
              found_flag_next = 1'b1;
            end
            answers_left_next = answers_left - 16'd1;
            section_end       = 1'b1;
          end
        end
        default: begin
          // Done, or an unused code: remaining bytes are ignored.
        end
      endcase

      // Move on to the next question, the next answer, or finish.
      if (section_end) begin
        label_left_next = 8'd0;
        field_pos_next  = 4'd0;
        if (questions_left_next != 16'd0) begin
          phase_next = dre_pkg::PH_Q_NAME;
        end else if (answers_left_next != 16'd0) begin
          phase_next = dre_pkg::PH_A_NAME;
        end else begin
          phase_next = dre_pkg::PH_DONE;
        end
      end

      byte_count_next = byte_count + CountW'(1);
    end
  end

  // Parse state registers. The last byte of a message returns them to reset.
  always_ff @(posedge clk) begin
    if (rst || (accept && msg.last_byte)) begin
      phase          <= dre_pkg::PH_HDR;
      field_pos      <= 4'd0;
      questions_left <= 16'd0;
      answers_left   <= 16'd0;
      label_left     <= 8'd0;
      record_type    <= 16'd0;
      rdata_left     <= 16'd0;
      ip_shift       <= 32'd0;
      found_flag     <= 1'b0;
      response_code  <= 4'd0;
      byte_count     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      field_pos      <= field_pos_next;
      questions_left <= questions_left_next;
      answers_left   <= answers_left_next;
      label_left     <= label_left_next;
      record_type    <= record_type_next;
      rdata_left     <= rdata_left_next;
      ip_shift       <= ip_shift_next;
      found_flag     <= found_flag_next;
      response_code  <= response_code_next;
      byte_count     <= byte_count_next;
    end
  end

  // Result register: loaded from the state after the last byte is parsed.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && msg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.last_byte) begin
      res_ip    <= ip_shift_next;
      res_found <= found_flag_next;
      res_rcode <= response_code_next;
      res_trunc <= (phase_next != dre_pkg::PH_DONE);
    end
  end

  assign res.valid     = res_valid;
  assign res.ip_addr   = res_ip;
  assign res.ip_found  = res_found;
  assign res.rcode     = res_rcode;
  assign res.fail      = (res_rcode != 4'd0);
  assign res.truncated = res_trunc;

endmodule

FILE: rtl/dre_checker.sv
// Port-level checks for the DNS response IPv4 extractor.
// Depends on dns_response_ipv4_extractor_core and dre_if.sv; bound below.
module dre_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_ip,
  input logic [3:0]  out_rcode,
  input logic        out_fail
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_ip) && $stable(out_rcode))
    else $error("result changed while stalled");

  // The last byte of a message always yields a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result after last byte");

  // A fresh result only follows an accepted last byte.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result without last byte");

  // The fail flag tracks the response code.
  a_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_fail == (out_rcode != 4'd0)))
    else $error("fail flag disagrees with rcode");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dns_response_ipv4_extractor_core dre_checker u_dre_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_last   (msg.last_byte),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_ip    (res.ip_addr),
  .out_rcode (res.rcode),
  .out_fail  (res.fail)
);

FILE: test/dns_response_ipv4_extractor_core_checker.sv
// Checker for the DNS response IPv4 extractor: watches both channels, predicts
// every result from the accepted message bytes and compares it with what arrives.
// Depends on dre_pkg (phase type, DNS constants) and dre_if.sv (channel interfaces).
module dns_response_ipv4_extractor_core_checker #(
  parameter int unsigned MAX_MSG_BYTES = dre_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  dre_in_if    msg,
  dre_out_if   res,
  output int   mismatch_count,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic [31:0] ip_addr;
    logic        ip_found;
    logic [3:0]  rcode;
    logic        fail;
    logic        truncated;
  } dns_answer_t;

  dns_answer_t lookup_q[$];

  // Predicted parse state.
  dre_pkg::phase_t parse_phase;
  logic [3:0]      field_idx;
  logic [15:0]     qd_left;
  logic [15:0]     an_left;
  logic [7:0]      label_left;
  logic [15:0]     rec_type;
  logic [15:0]     rdlen_left;
  logic [31:0]     addr_acc;
  logic            addr_seen;
  logic [3:0]      resp_code;
  int unsigned     bytes_in;

  function void clear_parse_state();
    parse_phase = dre_pkg::PH_HDR;
    field_idx   = '0;
    qd_left     = '0;
    an_left     = '0;
    label_left  = '0;
    rec_type    = '0;
    rdlen_left  = '0;
    addr_acc    = '0;
    addr_seen   = 1'b0;
    resp_code   = '0;
    bytes_in    = 0;
  endfunction

  function void enter_next_section();
    label_left = '0;
    field_idx  = '0;
    if (qd_left != 0) parse_phase = dre_pkg::PH_Q_NAME;
    else if (an_left != 0) parse_phase = dre_pkg::PH_A_NAME;
    else parse_phase = dre_pkg::PH_DONE;
  endfunction

  function void step_name(input logic [7:0] b, input dre_pkg::phase_t ptr_ph,
                          input dre_pkg::phase_t fixed_ph);
    if (label_left != 0) begin
      label_left = label_left - 8'd1;
    end else if ((b & dre_pkg::PTR_MASK) == dre_pkg::PTR_MASK) begin
      parse_phase = ptr_ph;
    end else if (b == 8'd0) begin
      parse_phase = fixed_ph;
      field_idx   = '0;
    end else begin
      label_left = b;
    end
  endfunction

  function void parse_msg_byte(input logic [7:0] b);
    case (parse_phase)
      dre_pkg::PH_HDR: begin
        if (bytes_in == dre_pkg::HDR_FLAGS_LO) resp_code = b[3:0];
        else if (bytes_in == dre_pkg::HDR_QD_HI) qd_left = {b, 8'h00};
        else if (bytes_in == dre_pkg::HDR_QD_LO) qd_left = qd_left | {8'h00, b};
        else if (bytes_in == dre_pkg::HDR_AN_HI) an_left = {b, 8'h00};
        else if (bytes_in == dre_pkg::HDR_AN_LO) an_left = an_left | {8'h00, b};
        if (bytes_in >= dre_pkg::HDR_LAST) enter_next_section();
      end
      dre_pkg::PH_Q_NAME: step_name(b, dre_pkg::PH_Q_PTR, dre_pkg::PH_Q_FIXED);
      dre_pkg::PH_Q_PTR: begin
        parse_phase = dre_pkg::PH_Q_FIXED;
        field_idx   = '0;
      end
      dre_pkg::PH_Q_FIXED: begin
        field_idx = field_idx + 4'd1;
        if (field_idx >= dre_pkg::Q_FIXED_LEN) begin
          qd_left = qd_left - 16'd1;
          enter_next_section();
        end
      end
      dre_pkg::PH_A_NAME: step_name(b, dre_pkg::PH_A_PTR, dre_pkg::PH_A_FIXED);
      dre_pkg::PH_A_PTR: begin
        parse_phase = dre_pkg::PH_A_FIXED;
        field_idx   = '0;
      end
      dre_pkg::PH_A_FIXED: begin
        if (field_idx == dre_pkg::A_TYPE_HI) rec_type = {b, 8'h00};
        else if (field_idx == dre_pkg::A_TYPE_LO) rec_type = rec_type | {8'h00, b};
        else if (field_idx == dre_pkg::A_RDLEN_HI) rdlen_left = {b, 8'h00};
        else if (field_idx == dre_pkg::A_RDLEN_LO) rdlen_left = rdlen_left | {8'h00, b};
        field_idx = field_idx + 4'd1;
        if (field_idx >= dre_pkg::A_FIXED_LEN) begin
          if (rdlen_left == 0) begin
            an_left = an_left - 16'd1;
            enter_next_section();
          end else begin
            // From here on field_idx says whether the rdata is an address.
            field_idx   = (rec_type == dre_pkg::TYPE_A_CODE &&
                           rdlen_left == dre_pkg::A_RDLENGTH) ? 4'd1 : 4'd0;
            parse_phase = dre_pkg::PH_RDATA;
          end
        end
      end
      dre_pkg::PH_RDATA: begin
        if (field_idx != 0) addr_acc = {addr_acc[23:0], b};
        rdlen_left = rdlen_left - 16'd1;
        if (rdlen_left == 0) begin
          if (field_idx != 0) addr_seen = 1'b1;
          an_left = an_left - 16'd1;
          enter_next_section();
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    dns_answer_t want;
    dns_answer_t next_answer;
    if (rst) begin
      clear_parse_state();
      lookup_q.delete();
      pending        = 0;
      mismatch_count = 0;
      results_seen   = 0;
    end else begin
      // The result register holds only results of earlier messages, so the
      // comparison comes before this edge's byte is predicted.
      if (res.valid && res.ready) begin
        results_seen++;
        if (lookup_q.size() == 0) begin
          report_mismatch("result with nothing predicted", res.ip_addr, '0);
        end else begin
          want = lookup_q.pop_front();
          if (res.ip_addr !== want.ip_addr)
            report_mismatch("ip_addr", res.ip_addr, want.ip_addr);
          if (res.ip_found !== want.ip_found)
            report_mismatch("ip_found", {31'd0, res.ip_found}, {31'd0, want.ip_found});
          if (res.rcode !== want.rcode)
            report_mismatch("rcode", {28'd0, res.rcode}, {28'd0, want.rcode});
          if (res.fail !== want.fail)
            report_mismatch("fail", {31'd0, res.fail}, {31'd0, want.fail});
          if (res.truncated !== want.truncated)
            report_mismatch("truncated", {31'd0, res.truncated}, {31'd0, want.truncated});
        end
      end
      if (msg.valid && msg.ready) begin
        if (bytes_in < MAX_MSG_BYTES) begin
          parse_msg_byte(msg.msg_byte);
          bytes_in++;
        end
        if (msg.last_byte) begin
          next_answer.ip_addr   = addr_acc;
          next_answer.ip_found  = addr_seen;
          next_answer.rcode     = resp_code;
          next_answer.fail      = (resp_code != 0);
          next_answer.truncated = (parse_phase != dre_pkg::PH_DONE);
          lookup_q.push_back(next_answer);
          clear_parse_state();
        end
      end
      pending = lookup_q.size();
    end
  end

endmodule

FILE: test/dns_response_ipv4_extractor_core_tb.sv
// Testbench top for the DNS response IPv4 extractor: builds DNS responses,
// drives them byte by byte and gives the verdict from the checker's count.
// Depends on dre_pkg, dre_if.sv, the core and dns_response_ipv4_extractor_core_checker.
module dns_response_ipv4_extractor_core_tb;

  // Number of message bytes after which the random part stops.
  localparam int unsigned ITEM_TARGET    = 1850;
  // Cycles without any transaction on either channel before the run is abandoned.
  // The longest legitimate quiet stretch is the long receiver hold below.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  // Length of the deliberate receiver hold, long enough to back the block up.
  localparam int unsigned LONG_HOLD      = 300;
  // The result register is loaded when the last byte is taken, so waiting
  // after the final result has been taken catches anything spurious.
  localparam int unsigned DRAIN_CYCLES   = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  dre_in_if  msg_ch ();
  dre_out_if res_ch ();

  int mismatch_count;
  int pending;
  int results_seen;

  dns_response_ipv4_extractor_core dut (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .res (res_ch)
  );

  dns_response_ipv4_extractor_core_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .msg            (msg_ch),
    .res            (res_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .results_seen   (results_seen)
  );

  // Idle rates in percent; the sender's is used only by the stimulus process,
  // the receiver's is handed over with nonblocking writes at the falling edge.
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 45;

  // A long hold is asked for by bumping hold_requests; the receiver process
  // serves each request and counts the hold out itself.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;

  // The message under construction, one entry per byte.
  logic [7:0] frame_q[$];

  // Receiver: random back-pressure, with a long hold whenever one is requested.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Offers one byte from a falling edge and returns at the falling edge after
  // the transaction. Valid stays high between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.msg_byte  <= b;
    msg_ch.last_byte <= is_last;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int unsigned n;
    n = frame_q.size();
    for (int unsigned i = 0; i < n; i++) send_byte(frame_q[i], i == n - 1);
    frame_q.delete();
    frames_sent++;
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic wait_drained();
    msg_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [3:0] pick_rcode();
    return ($urandom_range(9) < 6) ? 4'd0 : 4'($urandom_range(1, 15));
  endfunction

  task automatic push_word(input logic [15:0] w);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // Header: id, flags with the response code in the low nibble, the question
  // and answer counts, then random authority and additional counts.
  task automatic push_header(input logic [3:0] rc, input logic [15:0] qd, input logic [15:0] an);
    push_word(16'($urandom));
    frame_q.push_back(8'($urandom));
    frame_q.push_back({4'($urandom), rc});
    push_word(qd);
    push_word(an);
    push_random(4);
  endtask

  task automatic push_label(input logic [7:0] len);
    frame_q.push_back(len);
    push_random(len);
  endtask

  // A name of up to two labels, ended by a zero byte or by a compression pointer.
  // Now and then a label length uses the range 0x40 to 0xbf, which the block
  // still takes at its full value.
  task automatic push_name();
    int unsigned labels;
    labels = $urandom_range(0, 2);
    repeat (labels) begin
      if ($urandom_range(19) == 0) push_label(8'($urandom_range(8'h40, 8'hbf)));
      else push_label(8'($urandom_range(1, 8)));
    end
    if ($urandom_range(9) < 7) begin
      frame_q.push_back(8'h00);
    end else begin
      frame_q.push_back(dre_pkg::PTR_MASK | 8'($urandom_range(0, 63)));
      frame_q.push_back(8'($urandom));
    end
  endtask

  task automatic push_question();
    push_name();
    push_random(4);
  endtask

  // Fixed part of an answer (type, class, ttl, rdlength) and its rdata.
  task automatic push_record(input logic [15:0] rtype, input logic [15:0] rdlen,
                             input int unsigned data_len);
    push_word(rtype);
    push_random(6);
    push_word(rdlen);
    push_random(data_len);
  endtask

  task automatic push_answer(input logic [15:0] rtype, input logic [15:0] rdlen,
                             input int unsigned data_len);
    push_name();
    push_record(rtype, rdlen, data_len);
  endtask

  // Mostly well-formed responses with random content; some are cut short,
  // some carry counts that are never met, and a few are plain noise.
  task automatic build_random_frame();
    int unsigned sel;
    int unsigned keep;
    int unsigned data_len;
    logic [15:0] qd;
    logic [15:0] an;
    logic [15:0] rtype;
    logic [15:0] rdlen;
    if ($urandom_range(99) < 6) begin
      push_random($urandom_range(1, 40));
      return;
    end
    qd = ($urandom_range(24) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    an = ($urandom_range(24) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    push_header(pick_rcode(), qd, an);
    repeat ((qd > 3) ? 3 : qd) push_question();
    repeat ((an > 4) ? 4 : an) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        rtype = dre_pkg::TYPE_A_CODE;
        rdlen = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 8)) : dre_pkg::A_RDLENGTH;
      end else if (sel < 60) begin
        // Low byte matches type A, high byte does not.
        rtype = {8'($urandom_range(1, 255)), 8'h01};
        rdlen = dre_pkg::A_RDLENGTH;
      end else if (sel < 65) begin
        rtype = 16'($urandom);
        rdlen = 16'($urandom);
      end else begin
        rtype = 16'($urandom_range(2, 255));
        rdlen = 16'($urandom_range(0, 12));
      end
      data_len = (rdlen > 32) ? $urandom_range(0, 16) : rdlen;
      push_answer(rtype, rdlen, data_len);
    end
    push_random($urandom_range(0, 4));
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, frame_q.size());
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
  endtask

  initial begin
    int unsigned stage;
    stage = 0;
    msg_ch.valid     = 1'b0;
    msg_ch.msg_byte  = 8'h00;
    msg_ch.last_byte = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A message of a single byte, both extremes of the byte.
    frame_q.push_back(8'h00);
    send_frame();
    frame_q.push_back(8'hff);
    send_frame();

    // Header alone with zero counts: parsing is complete right after it.
    push_header(4'd3, 16'd0, 16'd0);
    send_frame();

    // One question, one A record.
    push_header(4'd0, 16'd1, 16'd1);
    push_question();
    push_answer(dre_pkg::TYPE_A_CODE, dre_pkg::A_RDLENGTH, 4);
    send_frame();

    // A label length of 0x45 taken at full value, a compression pointer in an
    // answer name, a record of another type skipped by rdlength, an A record
    // of the wrong length, the last A record winning and trailing bytes.
    push_header(4'd0, 16'd2, 16'd5);
    push_label(8'h45);
    frame_q.push_back(8'h00);
    push_random(4);
    push_question();
    push_answer(dre_pkg::TYPE_A_CODE, dre_pkg::A_RDLENGTH, 4);
    frame_q.push_back(8'hc0);
    frame_q.push_back(8'h0c);
    push_record(16'h0005, 16'd7, 7);
    push_answer(dre_pkg::TYPE_A_CODE, 16'd6, 6);
    push_answer(dre_pkg::TYPE_A_CODE, 16'd0, 0);
    push_answer(dre_pkg::TYPE_A_CODE, dre_pkg::A_RDLENGTH, 4);
    push_random(3);
    send_frame();

    // Message ending inside the rdata of an A record.
    push_header(4'd0, 16'd0, 16'd1);
    frame_q.push_back(8'h00);
    push_record(dre_pkg::TYPE_A_CODE, dre_pkg::A_RDLENGTH, 2);
    send_frame();

    // All ones and all zeros.
    repeat (20) frame_q.push_back(8'hff);
    send_frame();
    repeat (14) frame_q.push_back(8'h00);
    send_frame();
    wait_drained();

    // Random part in three stages of idling, the sender pausing for all
    // results at each change.
    while (bytes_sent < ITEM_TARGET) begin
      if (stage == 0 && bytes_sent >= ITEM_TARGET / 3) begin
        wait_drained();
        send_idle_pct = 45;
        recv_idle_pct <= 18;
        stage = 1;
      end else if (stage == 1 && bytes_sent >= 2 * ITEM_TARGET / 3) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        stage = 2;
        // The receiver holds off while short responses keep coming, so the
        // result register fills and the byte channel stalls.
        hold_requests <= hold_requests + 1;
        repeat (5) begin
          push_header(pick_rcode(), 16'd0, 16'd0);
          send_frame();
        end
        wait_drained();
        // An oversized response: a long skipped record puts an A address
        // across the byte limit, so only its first two octets are parsed.
        push_header(4'd0, 16'd0, 16'd2);
        frame_q.push_back(8'h00);
        push_record(16'h0010, 16'd476, 476);
        frame_q.push_back(8'h00);
        push_record(dre_pkg::TYPE_A_CODE, dre_pkg::A_RDLENGTH, 4);
        push_random(6);
        send_frame();
      end
      build_random_frame();
      send_frame();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d message bytes in %0d responses, %0d results compared",
             bytes_sent, frames_sent, results_seen);
    $display("mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
